// ===== hw/rtl/psd_pkg.sv =====
// Shared types for the point sort and dedup block.
package psd_pkg;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } psd_ctrl_t;

endpackage

// ===== hw/rtl/point_sort_dedup.sv =====
// Top level: stable sort of a set of 3D points with duplicate removal.
//
// Input channel (in_*): one point per request, valid/stall handshake. A set
// ends with the request that has in_last_in set. While loading, a point is
// taken every cycle: it is compared against all stored points at once and
// the chain of cells shifts by one to open its slot (one wide compare per
// cell). A point equal to a stored one is dropped, keeping the first label.
// Points beyond MAX_POINTS in one set are dropped but the set still ends.
// Output channel (out_*): after the last request, the sorted survivors leave
// from the head of the chain, one per cycle while out_stall is low, the
// first on the cycle after the last input is taken; out_last_out marks the
// final one. While results drain, in_stall is high. Results come straight
// from the head cell register and hold while out_stall is high.
// Reset (synchronous, rst_n low) empties the chain and the point count; no
// clearing pass is needed.
module point_sort_dedup #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [15:0]                  in_label_id,
  input  logic                         in_last_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic [15:0]                  out_label,
  output logic                         out_last_out
);
  import psd_pkg::*;

  localparam int KEY_BITS = 3 * COORD_BITS;
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam logic [COORD_BITS-1:0] SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic             drain_r, drain_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                in_acc, out_acc, full, any_eq;
  logic [KEY_BITS-1:0] new_key;
  psd_ctrl_t           ctrl;

  logic [MAX_POINTS-1:0] v_vec, lt_vec, eq_vec;
  logic [KEY_BITS-1:0]   k_arr [MAX_POINTS];
  logic [15:0]           l_arr [MAX_POINTS];

  assign in_stall = drain_r;
  assign in_acc   = in_valid && !drain_r;
  assign out_acc  = out_valid && !out_stall;
  assign full     = (cnt_r == CNT_W'(MAX_POINTS));
  assign any_eq   = |eq_vec;

  // sign bits flipped so an unsigned compare gives the signed order
  assign new_key = {in_coord_x ^ SIGN, in_coord_y ^ SIGN, in_coord_z ^ SIGN};

  assign ctrl.insert    = in_acc && !full && !any_eq;
  assign ctrl.shift_out = out_acc;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic                pv, plt, nv;
    logic [KEY_BITS-1:0] pk, nk;
    logic [15:0]         pl, nl;

    if (i == 0) begin : g_head
      assign pv  = 1'b0;
      assign pk  = '0;
      assign pl  = '0;
      assign plt = 1'b0;
    end else begin : g_body
      assign pv  = v_vec[i-1];
      assign pk  = k_arr[i-1];
      assign pl  = l_arr[i-1];
      assign plt = lt_vec[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign nv = 1'b0;
      assign nk = '0;
      assign nl = '0;
    end else begin : g_mid
      assign nv = v_vec[i+1];
      assign nk = k_arr[i+1];
      assign nl = l_arr[i+1];
    end

    psd_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_key    (new_key),
      .new_label  (in_label_id),
      .prev_valid (pv),
      .prev_key   (pk),
      .prev_label (pl),
      .prev_lt    (plt),
      .next_valid (nv),
      .next_key   (nk),
      .next_label (nl),
      .valid      (v_vec[i]),
      .key        (k_arr[i]),
      .label      (l_arr[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    drain_nxt = drain_r;
    cnt_nxt   = cnt_r;
    priority if (in_acc && in_last_in) begin
      drain_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (in_acc && !full) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (out_acc && out_last_out) begin
      drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      drain_r <= drain_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid    = drain_r && v_vec[0];
  assign out_x        = k_arr[0][KEY_BITS-1 -: COORD_BITS] ^ SIGN;
  assign out_y        = k_arr[0][2*COORD_BITS-1 -: COORD_BITS] ^ SIGN;
  assign out_z        = k_arr[0][COORD_BITS-1:0] ^ SIGN;
  assign out_label    = l_arr[0];
  assign out_last_out = !v_vec[1];

  a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> v_vec[0])
    else $error("drain with empty head cell");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((v_vec >> 1) & ~v_vec) == '0)
    else $error("hole in the cell chain");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !drain_r |-> ($countones(v_vec) <= int'(cnt_r)))
    else $error("more stored points than counted");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_out) |=> !out_valid && !in_stall)
    else $error("chain not empty after final result");

endmodule

// ===== hw/rtl/psd_cell.sv =====
// One cell of the sorting chain: holds a point and moves it to a neighbor.
module psd_cell #(
  parameter int KEY_BITS = 96
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psd_pkg::psd_ctrl_t    ctrl,
  input  logic [KEY_BITS-1:0]   new_key,
  input  logic [15:0]           new_label,
  input  logic                  prev_valid,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [15:0]           prev_label,
  input  logic                  prev_lt,
  input  logic                  next_valid,
  input  logic [KEY_BITS-1:0]   next_key,
  input  logic [15:0]           next_label,
  output logic                  valid,
  output logic [KEY_BITS-1:0]   key,
  output logic [15:0]           label,
  output logic                  lt,
  output logic                  eq
);
  import psd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [15:0]         label_r, label_nxt;

  // new point sorts strictly before this entry; empty cells act as +inf
  assign lt = !valid_r || (new_key < key_r);
  assign eq = valid_r && (new_key == key_r);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    label_nxt = label_r;
    priority if (ctrl.shift_out) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
      label_nxt = next_label;
    end else if (ctrl.insert && lt) begin
      if (prev_lt) begin
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
        label_nxt = prev_label;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        label_nxt = new_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    label_r <= label_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign label = label_r;

endmodule

// ===== test/tb_top.sv =====
// Testbench for point_sort_dedup: directed and random point sets checked against a sort and dedup predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_PTS = 64;
  localparam int COORD_W = 32;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [15:0]               label;
    logic                      last;
  } point_t;

  typedef struct {
    point_t pt;
    bit     hold;
  } point_req_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;
  logic [15:0]               in_label_id = '0;
  logic                      in_last_in = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [15:0]               out_label;
  logic                      out_last_out;

  point_req_t point_reqs_q[$];
  point_t     loaded_pts[$];
  point_t     survivors_q[$];
  int         n_items = 0;
  int         accepted_cnt = 0;
  int         err_cnt = 0;
  int         send_gap = 0;
  int         send_idle_pct = 10;
  int         recv_gap = 0;
  int         recv_idle_pct = 10;
  int         recv_cycles = 0;
  bit         quiet;

  point_sort_dedup #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_coord_x  (in_coord_x),
    .in_coord_y  (in_coord_y),
    .in_coord_z  (in_coord_z),
    .in_label_id (in_label_id),
    .in_last_in  (in_last_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_label   (out_label),
    .out_last_out(out_last_out)
  );

  assign quiet = (accepted_cnt >= n_items - 40);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit same_coords(point_t a, point_t b);
    return a.x == b.x && a.y == b.y && a.z == b.z;
  endfunction

  function automatic bit sorts_after(point_t a, point_t b);
    if (a.x != b.x) return $signed(a.x) > $signed(b.x);
    if (a.y != b.y) return $signed(a.y) > $signed(b.y);
    return $signed(a.z) > $signed(b.z);
  endfunction

  // store the point; on the last request, stable-sort the set and keep first of each run
  function automatic void load_point(point_t p);
    point_t srt[MAX_PTS];
    point_t kept[$];
    point_t r;
    int n;
    int j;
    n = 0;
    if (loaded_pts.size() < MAX_PTS) loaded_pts = {loaded_pts, p};
    if (!p.last) return;
    foreach (loaded_pts[i]) begin
      j = n;
      while (j > 0 && sorts_after(srt[j-1], loaded_pts[i])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = loaded_pts[i];
      n++;
    end
    for (int i = 0; i < n; i++) begin
      if (i == 0 || !same_coords(srt[i-1], srt[i])) kept = {kept, srt[i]};
    end
    foreach (kept[k]) begin
      r = kept[k];
      r.last = (k == kept.size() - 1);
      survivors_q = {survivors_q, r};
    end
    loaded_pts.delete();
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_req(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z, logic [15:0] label,
                                   logic last, bit hold);
    point_req_t r;
    r.pt.x = x;
    r.pt.y = y;
    r.pt.z = z;
    r.pt.label = label;
    r.pt.last = last;
    r.hold = hold;
    point_reqs_q = {point_reqs_q, r};
  endfunction

  function automatic void add_set(int size, bit hold);
    point_t set_pts[$];
    point_t p;
    for (int i = 0; i < size; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        p = set_pts[$urandom_range(0, set_pts.size() - 1)];
      end else begin
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
      end
      p.label = 16'($urandom);
      p.last = (i == size - 1);
      set_pts = {set_pts, p};
      push_req(p.x, p.y, p.z, p.label, p.last, hold && i == 0);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    point_req_t cur;
    bit take;
    bit nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        cur.pt.x = in_coord_x;
        cur.pt.y = in_coord_y;
        cur.pt.z = in_coord_z;
        cur.pt.label = in_label_id;
        cur.pt.last = in_last_in;
        load_point(cur.pt);
        accepted_cnt++;
        if (in_last_in) begin
          case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 5;
            default: send_idle_pct = 25;
          endcase
        end
      end
      if (!in_valid || take) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 16) - 1;
        end else if (point_reqs_q.size() > 0 &&
                     (!point_reqs_q[0].hold || survivors_q.size() == 0)) begin
          cur = point_reqs_q.pop_front();
          nv = 1'b1;
          in_coord_x <= cur.pt.x;
          in_coord_y <= cur.pt.y;
          in_coord_z <= cur.pt.z;
          in_label_id <= cur.pt.label;
          in_last_in <= cur.pt.last;
        end
        in_valid <= nv;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (survivors_q.size() == 0) begin
          report_mismatch("unexpected result x", out_x, '0);
        end else begin
          want = survivors_q.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
          if (out_label !== want.label)
            report_mismatch("out_label", COORD_W'(out_label), COORD_W'(want.label));
          if (out_last_out !== want.last)
            report_mismatch("out_last_out", COORD_W'(out_last_out), COORD_W'(want.last));
        end
      end
      recv_cycles++;
      if (recv_cycles % 97 == 0) begin
        case ($urandom_range(0, 2))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 5;
          default: recv_idle_pct = 25;
        endcase
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    // single point, extremes
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff, 1'b1, 1'b0);
    // sign order, ties on x and on x/y, duplicates keep the first label
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 1'b0, 1'b0);
    push_req(5, 1, 1, 16'd1, 1'b0, 1'b0);
    push_req(-5, 1, 1, 16'd2, 1'b0, 1'b0);
    push_req(5, 0, 1, 16'd3, 1'b0, 1'b0);
    push_req(5, 1, 0, 16'd4, 1'b0, 1'b0);
    push_req(5, 1, 1, 16'd5, 1'b0, 1'b0);
    push_req(32'h8000_0000, 32'h7fff_ffff, 0, 16'd6, 1'b0, 1'b0);
    push_req(-5, 1, 1, 16'd7, 1'b0, 1'b0);
    push_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'd8, 1'b0, 1'b0);
    push_req(0, 0, 0, 16'd9, 1'b1, 1'b0);
    // all duplicates, sent only after the previous set has drained
    push_req(1, 2, 3, 16'd10, 1'b0, 1'b1);
    push_req(1, 2, 3, 16'd11, 1'b0, 1'b0);
    push_req(1, 2, 3, 16'd12, 1'b1, 1'b0);
    // reversed pair
    push_req(32'h7fff_ffff, 0, 0, 16'd13, 1'b0, 1'b0);
    push_req(32'h8000_0000, 0, 0, 16'd14, 1'b1, 1'b0);
    // alternating bit patterns
    push_req(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 1'b0, 1'b0);
    push_req(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 1'b1, 1'b0);

    add_set(MAX_PTS + 2, 1'b1);
    add_set(MAX_PTS, 1'b0);
    while (point_reqs_q.size() < 310)
      add_set($urandom_range(1, 12), $urandom_range(0, 7) == 0);
    n_items = point_reqs_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < n_items || survivors_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0)
      $display("[point_sort_dedup] OK");
    else
      $display("[point_sort_dedup] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[point_sort_dedup] ERROR");
    $finish;
  end

endmodule
